@@ src/ufe_pkg.sv @@
// Shared types and constants for the url-encoded form field extractor.
// Used by every module of the block and by its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ufe_pkg;

	localparam int MAX_KEY_BYTES = 8;

	localparam int KEY_W   = 64;
	localparam int KLEN_W  = 4;
	localparam int LIMIT_W = 8;
	localparam int CFG_W   = 64;
	localparam int CIDX_W  = 2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_KEY_TEXT    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_VALUE_LIMIT = 2'd2;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	typedef enum logic [1:0] {
		PH_MATCH = 2'd0,
		PH_SKIP  = 2'd1,
		PH_VALUE = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	// escape progress; UPPER also covers a decimal first digit
	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_UPPER = 2'd2,
		ESC_LOWER = 2'd3
	} esc_t;

	typedef enum logic [1:0] {
		OUT_PENDING   = 2'd0,
		OUT_FOUND     = 2'd1,
		OUT_NOT_FOUND = 2'd2,
		OUT_TOO_LONG  = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key_text;
		logic [KLEN_W-1:0]  key_length;
		logic [LIMIT_W-1:0] value_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n;
		outcome_t   outcome;
	} result_t;

endpackage

`default_nettype wire

@@ src/ufe_cfg_regs.sv @@
// Configuration registers of the form field extractor: key, key length, limit.
// Depends on ufe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufe_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ufe_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [ufe_pkg::CFG_W-1:0]  cfg_data,
	output ufe_pkg::cfg_t                   cfg
);
	import ufe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_text    <= '0;
			cfg_q.key_length  <= KLEN_W'(1);
			cfg_q.value_limit <= LIMIT_W'(63);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_TEXT:    cfg_q.key_text    <= cfg_data[KEY_W-1:0];
				CFG_KEY_LENGTH:  cfg_q.key_length  <= cfg_data[KLEN_W-1:0];
				CFG_VALUE_LIMIT: cfg_q.value_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/ufe_scan_core.sv @@
// Scan state and per-byte step logic: key match, skip, value decode, end of body.
// Depends on ufe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufe_scan_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    advance,
	input  wire logic [7:0] byte_in,
	input  wire logic    last_in,
	input  wire ufe_pkg::cfg_t cfg,
	output ufe_pkg::result_t result
);
	import ufe_pkg::*;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] key_pos;
		esc_t       esc;
		logic [3:0] nib;
		logic [7:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n;
		outcome_t   outcome;
	} work_t;

	phase_t     phase_q;
	logic [3:0] key_pos_q;
	esc_t       esc_q;
	logic [3:0] nib_q;
	logic [7:0] count_q;
	work_t      w;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
			(c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_0 && c <= CH_9)        v = c - CH_0;
		else if (c >= CH_LA && c <= CH_LF) v = c - CH_LA + 8'd10;
		else                               v = c - CH_UA + 8'd10;
		return v[3:0];
	endfunction

	function automatic logic [7:0] digit_char(input work_t x);
		logic [7:0] r;
		if (x.nib < 4'd10)          r = CH_0 + {4'd0, x.nib};
		else if (x.esc == ESC_LOWER) r = CH_LA + {4'd0, x.nib} - 8'd10;
		else                        r = CH_UA + {4'd0, x.nib} - 8'd10;
		return r;
	endfunction

	function automatic work_t put_byte(input work_t x, input logic [7:0] c,
			input logic [7:0] lim);
		work_t y;
		y = x;
		if (y.phase == PH_VALUE) begin
			if (y.count >= lim) begin
				y.outcome = OUT_TOO_LONG;
				y.phase   = PH_DONE;
				y.esc     = ESC_NONE;
			end else begin
				unique case (y.n)
					2'd0: y.b0 = c;
					2'd1: y.b1 = c;
					2'd2: y.b2 = c;
					2'd3: ;
				endcase
				if (y.n != 2'd3) y.n = y.n + 2'd1;
				y.count = y.count + 8'd1;
			end
		end
		return y;
	endfunction

	function automatic work_t plain_byte(input work_t x, input logic [7:0] c,
			input logic [7:0] lim);
		work_t y;
		y = x;
		if (y.phase == PH_VALUE) begin
			priority if (c == CH_AMP) begin
				y.outcome = OUT_FOUND;
				y.phase   = PH_DONE;
			end else if (c == CH_PLUS) begin
				y = put_byte(y, CH_SPACE, lim);
			end else if (c == CH_PCT) begin
				y.esc = ESC_PCT;
			end else begin
				y = put_byte(y, c, lim);
			end
		end
		return y;
	endfunction

	// one input byte, worked through in the order the decoder defines
	always_comb begin
		logic [3:0] kl;
		logic [7:0] kb;
		logic [7:0] d;
		logic [7:0] lim;
		lim = cfg.value_limit;
		kl  = (cfg.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : cfg.key_length;
		kb  = cfg.key_text[{key_pos_q[2:0], 3'b000} +: 8];
		d   = '0;

		w.phase   = phase_q;
		w.key_pos = key_pos_q;
		w.esc     = esc_q;
		w.nib     = nib_q;
		w.count   = count_q;
		w.b0      = '0;
		w.b1      = '0;
		w.b2      = '0;
		w.n       = '0;
		w.outcome = OUT_PENDING;

		unique case (phase_q)
			PH_MATCH: begin
				priority if (byte_in == CH_AMP) begin
					w.key_pos = '0;
				end else if (key_pos_q < kl) begin
					if (byte_in == kb) w.key_pos = key_pos_q + 4'd1;
					else               w.phase   = PH_SKIP;
				end else if (byte_in == CH_EQ) begin
					w.phase = PH_VALUE;
					w.esc   = ESC_NONE;
					w.count = '0;
				end else begin
					w.phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (byte_in == CH_AMP) begin
					w.phase   = PH_MATCH;
					w.key_pos = '0;
				end
			end
			PH_VALUE: begin
				unique case (esc_q)
					ESC_NONE: w = plain_byte(w, byte_in, lim);
					ESC_PCT: begin
						if (is_hex(byte_in)) begin
							w.nib = hex_val(byte_in);
							w.esc = (byte_in >= CH_LA && byte_in <= CH_LF) ?
								ESC_LOWER : ESC_UPPER;
						end else begin
							w.esc = ESC_NONE;
							w = put_byte(w, CH_PCT, lim);
							w = plain_byte(w, byte_in, lim);
						end
					end
					ESC_UPPER, ESC_LOWER: begin
						if (is_hex(byte_in)) begin
							w.esc = ESC_NONE;
							w = put_byte(w, {nib_q, hex_val(byte_in)}, lim);
						end else begin
							d = digit_char(w);
							w.esc = ESC_NONE;
							w = put_byte(w, CH_PCT, lim);
							w = put_byte(w, d, lim);
							w = plain_byte(w, byte_in, lim);
						end
					end
				endcase
			end
			PH_DONE: ;
		endcase

		// end of body: flush any pending escape literally, report, clear
		if (last_in) begin
			if (w.phase == PH_VALUE) begin
				if (w.esc == ESC_PCT) begin
					w.esc = ESC_NONE;
					w = put_byte(w, CH_PCT, lim);
				end else if (w.esc == ESC_UPPER || w.esc == ESC_LOWER) begin
					d = digit_char(w);
					w.esc = ESC_NONE;
					w = put_byte(w, CH_PCT, lim);
					w = put_byte(w, d, lim);
				end
				if (w.phase == PH_VALUE) w.outcome = OUT_FOUND;
			end else if (w.phase == PH_MATCH || w.phase == PH_SKIP) begin
				w.outcome = OUT_NOT_FOUND;
			end
			w.phase   = PH_MATCH;
			w.key_pos = '0;
			w.esc     = ESC_NONE;
			w.nib     = '0;
			w.count   = '0;
		end
	end

	// next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MATCH;
			key_pos_q <= '0;
			esc_q     <= ESC_NONE;
			nib_q     <= '0;
			count_q   <= '0;
		end else if (advance) begin
			phase_q   <= w.phase;
			key_pos_q <= w.key_pos;
			esc_q     <= w.esc;
			nib_q     <= w.nib;
			count_q   <= w.count;
		end
	end

	// outputs
	always_comb begin
		result.b0      = w.b0;
		result.b1      = w.b1;
		result.b2      = w.b2;
		result.n       = w.n;
		result.outcome = w.outcome;
	end

endmodule

`default_nettype wire

@@ src/urlencoded_field_extractor.sv @@
// Url-encoded form field extractor: stage 1 input register, scan step logic,
// stage 2 result register. Depends on ufe_pkg, ufe_cfg_regs, ufe_scan_core.
//
// Usage:
//   Body bytes arrive on body_valid/body_stall with body_byte and body_last.
//   Each accepted transaction yields exactly one result transaction on
//   result_valid/result_stall: up to three decoded value bytes (byte_count
//   says how many) and an outcome code (found, not found, too long, or
//   pending). body_last closes the body and clears the scan state.
//   A byte accepted into the input register steps through the scan logic into
//   the result register once that register is free; a stall holds it in stage 1.
//   Throughput: one byte per cycle while result_stall is low, limited by the
//   single step of scan logic between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   one more byte can still enter the input register; beyond that body_stall
//   is raised until the result is taken.
//   Reset (arst_n low) empties both stages, returns the scan to the start of
//   a body and loads key_text 0, key_length 1, value_limit 63.
//   Configuration writes take effect at once; the user must make them only while idle (the block does not check).
`timescale 1ns / 1ps
`default_nettype none

module urlencoded_field_extractor (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ufe_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [ufe_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       body_valid,
	output logic                            body_stall,
	input  wire logic [7:0]                 body_byte,
	input  wire logic                       body_last,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [7:0]                      value_byte_first,
	output logic [7:0]                      value_byte_second,
	output logic [7:0]                      value_byte_third,
	output logic [1:0]                      byte_count,
	output logic [1:0]                      outcome
);
	import ufe_pkg::*;

	cfg_t       cfg;
	result_t    step_res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	result_t    result_s2;
	logic       out_free;
	logic       advance;
	logic       take_in;

	assign out_free   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign body_stall = valid_s1 && !out_free;
	assign take_in    = body_valid && !body_stall;

	ufe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ufe_scan_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.cfg     (cfg),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)       valid_s1 <= 1'b1;
			else if (advance)  valid_s1 <= 1'b0;
			if (advance)       valid_s2 <= 1'b1;
			else if (out_free) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= body_byte;
			last_s1 <= body_last;
		end
		if (advance) result_s2 <= step_res;
	end

	assign result_valid      = valid_s2;
	assign value_byte_first  = result_s2.b0;
	assign value_byte_second = result_s2.b1;
	assign value_byte_third  = result_s2.b2;
	assign byte_count        = result_s2.n;
	assign outcome           = result_s2.outcome;

endmodule

`default_nettype wire

@@ src/ufe_checker.sv @@
// Port-level checker for the form field extractor, bound to the top level.
// Depends on ufe_pkg and urlencoded_field_extractor.
`timescale 1ns / 1ps
`default_nettype none

module ufe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [7:0] value_byte_first,
	input wire logic [7:0] value_byte_second,
	input wire logic [7:0] value_byte_third,
	input wire logic [1:0] byte_count,
	input wire logic [1:0] outcome
);
	import ufe_pkg::*;

	// unused byte slots read as zero
	a_slot_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && byte_count == 2'd0 |-> value_byte_first == 8'd0)
		else $error("first slot not zero with no bytes");

	a_slot_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (byte_count == 2'd0 || byte_count == 2'd1) |->
			value_byte_second == 8'd0 && value_byte_third == 8'd0)
		else $error("unused slot not zero");

	// no value bytes can come with a not-found report
	a_not_found_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && outcome == 2'(OUT_NOT_FOUND) |-> byte_count == 2'd0)
		else $error("value bytes with not-found outcome");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(outcome) &&
			$stable(byte_count) && $stable(value_byte_first))
		else $error("stalled result transaction changed");

endmodule

bind urlencoded_field_extractor ufe_checker u_ufe_checker (.*);

`default_nettype wire
